// File: src/ramr_pkg.sv
// Shared types and constants for the rational add/multiply/reduce pipeline.
// No dependencies; compile first.
package ramr_pkg;

	localparam int GCD_STAGES = 62;
	localparam int DIV_STAGES = 32;

	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_ZERO,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		logic  vld;
		logic  neg;
		kind_t kind;
	} tag_t;

	typedef struct packed {
		tag_t        tag;
		logic [31:0] mag;
		logic [29:0] den;
		logic [31:0] u;
		logic [31:0] v;
		logic [4:0]  k;
	} gcd_word_t;

	typedef struct packed {
		tag_t        tag;
		logic [29:0] g;
		logic [31:0] nq;
		logic [31:0] dq;
		logic [30:0] nr;
		logic [30:0] dr;
	} div_word_t;

endpackage

// File: src/ramr_if.sv
// Channel interfaces for the rational pipeline: input word and result word.
// No dependencies.
interface ramr_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [15:0] a_numer;
	logic [14:0]        a_denom;
	logic signed [15:0] b_numer;
	logic [14:0]        b_denom;

	modport source(output valid, func, a_numer, a_denom, b_numer, b_denom, input ready);
	modport sink(input valid, func, a_numer, a_denom, b_numer, b_denom, output ready);
endinterface

interface ramr_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_numer;
	logic [29:0]        res_denom;

	modport source(output valid, res_numer, res_denom, input ready);
	modport sink(input valid, res_numer, res_denom, output ready);
endinterface

// File: src/ramr_gcd_step.sv
// One registered step of the binary greatest-common-divisor pipeline.
// Depends on ramr_pkg.
module ramr_gcd_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ramr_pkg::gcd_word_t d,
	output ramr_pkg::gcd_word_t q
);
	import ramr_pkg::*;

	gcd_word_t w;

	always_comb begin
		w = d;
		if (d.v != 32'd0) begin
			if (!d.u[0] && !d.v[0]) begin
				w.u = d.u >> 1;
				w.v = d.v >> 1;
				w.k = d.k + 5'd1;
			end else if (!d.u[0]) begin
				w.u = d.u >> 1;
			end else if (!d.v[0]) begin
				w.v = d.v >> 1;
			end else if (d.u > d.v) begin
				// keep the smaller odd value, halve the even difference
				w.u = d.v;
				w.v = (d.u - d.v) >> 1;
			end else begin
				w.v = (d.v - d.u) >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.tag.vld <= 1'b0;
		end else if (en) begin
			q <= w;
		end
	end
endmodule

// File: src/ramr_div_step.sv
// One registered restoring-division step, applied to numerator and denominator at once.
// Depends on ramr_pkg.
module ramr_div_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ramr_pkg::div_word_t d,
	output ramr_pkg::div_word_t q
);
	import ramr_pkg::*;

	div_word_t   w;
	logic [30:0] nr_sh;
	logic [30:0] dr_sh;
	logic [30:0] dvs;

	always_comb begin
		w     = d;
		dvs   = {1'b0, d.g};
		nr_sh = {d.nr[29:0], d.nq[31]};
		dr_sh = {d.dr[29:0], d.dq[31]};
		if (nr_sh >= dvs) begin
			w.nr = nr_sh - dvs;
			w.nq = {d.nq[30:0], 1'b1};
		end else begin
			w.nr = nr_sh;
			w.nq = {d.nq[30:0], 1'b0};
		end
		if (dr_sh >= dvs) begin
			w.dr = dr_sh - dvs;
			w.dq = {d.dq[30:0], 1'b1};
		end else begin
			w.dr = dr_sh;
			w.dq = {d.dq[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.tag.vld <= 1'b0;
		end else if (en) begin
			q <= w;
		end
	end
endmodule

// File: src/rational_add_multiply_reduce.sv
// Rational add/multiply with reduction to lowest terms: a fully pipelined block that accepts
// one word per cycle and returns one result word per input word, in order. A word passes
// three front stages (capture, cross products, sum and sign), 62 binary-gcd steps, one stage
// forming the divisor, 32 restoring-division steps and the output register: 99 register
// stages. Throughput is one word per cycle; the whole pipeline holds when the output
// register is full and not taken, so ready falls only then. A raw numerator of zero
// gives 0/1; a zero input denominator gives 0/0 as an error mark.
// Depends on ramr_pkg, ramr_if, ramr_gcd_step and ramr_div_step.
module rational_add_multiply_reduce (
	input  logic clk,
	input  logic arst_n,
	ramr_in_if.sink    req,
	ramr_out_if.source rsp
);
	import ramr_pkg::*;

	logic adv;

	// front stage 1: captured operands
	logic               vld_s1;
	logic               func_s1;
	logic signed [15:0] an_s1;
	logic [14:0]        ad_s1;
	logic signed [15:0] bn_s1;
	logic [14:0]        bd_s1;

	// front stage 2: products
	logic               vld_s2;
	logic               func_s2;
	logic signed [31:0] p1_s2;
	logic signed [31:0] p2_s2;
	logic [29:0]        dd_s2;

	logic signed [31:0] p1_c;
	logic signed [31:0] p2_c;
	logic [29:0]        dd_c;
	logic signed [31:0] rn_c;
	gcd_word_t          g0_c;

	gcd_word_t gcd_s [GCD_STAGES+1];
	div_word_t div_s [DIV_STAGES+1];
	div_word_t d0_c;

	logic               vld_q;
	logic signed [31:0] numer_q;
	logic [29:0]        denom_q;

	// advance everything unless a finished result is waiting and not taken
	assign adv       = !vld_q || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= req.func;
			an_s1   <= req.a_numer;
			ad_s1   <= req.a_denom;
			bn_s1   <= req.b_numer;
			bd_s1   <= req.b_denom;
			func_s2 <= func_s1;
			p1_s2   <= p1_c;
			p2_s2   <= p2_c;
			dd_s2   <= dd_c;
		end
	end

	// cross products for an add, plain product for a multiply
	always_comb begin
		if (func_s1) begin
			p1_c = 32'(an_s1 * bn_s1);
			p2_c = 32'sd0;
		end else begin
			p1_c = 32'(an_s1 * $signed({1'b0, bd_s1}));
			p2_c = 32'(bn_s1 * $signed({1'b0, ad_s1}));
		end
		dd_c = 30'(ad_s1 * bd_s1);
	end

	// sum, sign and magnitude; seed the gcd with both raw values
	always_comb begin
		rn_c          = p1_s2 + p2_s2;
		g0_c.tag.vld  = vld_s2;
		g0_c.tag.neg  = rn_c[31];
		g0_c.mag      = rn_c[31] ? 32'(-rn_c) : 32'(rn_c);
		g0_c.den      = dd_s2;
		g0_c.k        = 5'd0;
		if (dd_s2 == 30'd0) begin
			g0_c.tag.kind = KIND_ERROR;
		end else if (rn_c == 32'sd0) begin
			g0_c.tag.kind = KIND_ZERO;
		end else begin
			g0_c.tag.kind = KIND_NORMAL;
		end
		if (g0_c.tag.kind == KIND_NORMAL) begin
			g0_c.u = g0_c.mag;
			g0_c.v = {2'b00, dd_s2};
		end else begin
			// settle special words at once
			g0_c.u = 32'd1;
			g0_c.v = 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcd_s[0].tag.vld <= 1'b0;
		end else if (adv) begin
			gcd_s[0] <= g0_c;
		end
	end

	for (genvar i = 0; i < GCD_STAGES; i++) begin : g_gcd
		ramr_gcd_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (gcd_s[i]),
			.q      (gcd_s[i+1])
		);
	end

	// restore the common power of two and load both dividends
	always_comb begin
		d0_c.tag = gcd_s[GCD_STAGES].tag;
		d0_c.g   = 30'(gcd_s[GCD_STAGES].u << gcd_s[GCD_STAGES].k);
		d0_c.nq  = gcd_s[GCD_STAGES].mag;
		d0_c.dq  = {2'b00, gcd_s[GCD_STAGES].den};
		d0_c.nr  = 31'd0;
		d0_c.dr  = 31'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0].tag.vld <= 1'b0;
		end else if (adv) begin
			div_s[0] <= d0_c;
		end
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		ramr_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (div_s[j]),
			.q      (div_s[j+1])
		);
	end

	// output register: apply the sign and the special cases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= div_s[DIV_STAGES].tag.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (div_s[DIV_STAGES].tag.kind)
				KIND_ZERO: begin
					numer_q <= 32'sd0;
					denom_q <= 30'd1;
				end
				KIND_ERROR: begin
					numer_q <= 32'sd0;
					denom_q <= 30'd0;
				end
				default: begin
					numer_q <= div_s[DIV_STAGES].tag.neg ? $signed(-div_s[DIV_STAGES].nq)
						: $signed(div_s[DIV_STAGES].nq);
					denom_q <= div_s[DIV_STAGES].dq[29:0];
				end
			endcase
		end
	end

	assign rsp.valid     = vld_q;
	assign rsp.res_numer = numer_q;
	assign rsp.res_denom = denom_q;
endmodule

// File: tb/rational_add_multiply_reduce_chk.sv
// Checker for the rational add/multiply/reduce block: watches both channels,
// predicts each result word and compares. Depends on ramr_if.
`timescale 1ns / 100ps

module rational_add_multiply_reduce_chk (
	input  logic clk,
	input  logic arst_n,
	ramr_in_if   req,
	ramr_out_if  rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct {
		logic signed [31:0] numer;
		logic [29:0]        denom;
	} fraction_t;

	fraction_t reduced_q[$];

	assign pending = reduced_q.size();

	function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic fraction_t reduce_fraction(logic mul, logic signed [15:0] an,
			logic [14:0] ad, logic signed [15:0] bn, logic [14:0] bd);
		longint          rn;
		longint          rd;
		longint unsigned mag;
		longint unsigned g;
		fraction_t       f;
		if (mul) begin
			rn = longint'(an) * longint'(bn);
		end else begin
			rn = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
		end
		rd = longint'(ad) * longint'(bd);
		if (rd == 0) begin
			f.numer = '0;
			f.denom = '0;
		end else if (rn == 0) begin
			f.numer = '0;
			f.denom = 30'd1;
		end else begin
			mag = (rn < 0) ? longint'(-rn) : rn;
			g = euclid_gcd(mag, rd);
			mag = mag / g;
			f.denom = 30'(longint'(rd) / longint'(g));
			f.numer = (rn < 0) ? -32'(mag) : 32'(mag);
		end
		return f;
	endfunction

	always @(posedge clk) begin
		fraction_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				reduced_q.push_back(reduce_fraction(req.func, req.a_numer, req.a_denom,
					req.b_numer, req.b_denom));
			end
			if (rsp.valid && rsp.ready) begin
				if (reduced_q.size() == 0) begin
					$error("unexpected result word %0d/%0d", rsp.res_numer, rsp.res_denom);
					fail_count = fail_count + 1;
				end else begin
					want = reduced_q.pop_front();
					if (rsp.res_numer !== want.numer) begin
						$error("res_numer: expected %0d, got %0d", want.numer, rsp.res_numer);
						fail_count = fail_count + 1;
					end
					if (rsp.res_denom !== want.denom) begin
						$error("res_denom: expected %0d, got %0d", want.denom, rsp.res_denom);
						fail_count = fail_count + 1;
					end
				end
			end
		end
	end

	initial fail_count = 0;

endmodule

// File: tb/rational_add_multiply_reduce_tb.sv
// Testbench top for rational_add_multiply_reduce: drives directed and random fraction
// words with random gaps and back-pressure. Depends on ramr_if, the block and the checker.
`timescale 1ns / 100ps

module rational_add_multiply_reduce_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;

	ramr_in_if  req();
	ramr_out_if rsp();

	rational_add_multiply_reduce dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	rational_add_multiply_reduce_chk chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one; a third of the time none at all.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 60);
	endfunction

	// Hold the word until it is taken; valid drops only during a gap before the next word or once no word follows.
	task automatic send_word(logic f, logic signed [15:0] an, logic [14:0] ad,
			logic signed [15:0] bn, logic [14:0] bd);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req.valid   <= 1'b1;
		req.func    <= f;
		req.a_numer <= an;
		req.a_denom <= ad;
		req.b_numer <= bn;
		req.b_denom <= bd;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// Pick a numerator: three times in eight an extreme, once in eight a small value from -3 to 3, otherwise anywhere.
	function automatic logic signed [15:0] pick_numer();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return -16'sd32767;
			2: return 16'sh8000;
			3: return 16'($urandom_range(0, 6)) - 16'sd3;
			default: return 16'($urandom);
		endcase
	endfunction

	// Small denominators give plenty of common factors; zero now and then.
	function automatic logic [14:0] pick_denom();
		case ($urandom_range(0, 19))
			0: return 15'd0;
			1: return 15'h7fff;
			2, 3, 4, 5, 6: return 15'($urandom_range(1, 12));
			7, 8, 9: return 15'(1 << $urandom_range(0, 14));
			default: return 15'($urandom_range(1, 32767));
		endcase
	endfunction

	// Drive the result side's ready with its own random stalls.
	initial begin
		int g;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp.ready <= 1'b1;
			g = gap_len();
			if (g > 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
		end
	end

	initial begin
		int n;
		req.valid   = 1'b0;
		req.func    = 1'b0;
		req.a_numer = '0;
		req.a_denom = 15'd1;
		req.b_numer = '0;
		req.b_denom = 15'd1;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, both operations, zero numerators and zero denominators.
		send_word(1'b0, 16'sd1, 15'd2, 16'sd1, 15'd3);
		send_word(1'b1, 16'sd2, 15'd3, 16'sd3, 15'd4);
		send_word(1'b0, 16'sd1, 15'd2, -16'sd1, 15'd2);
		send_word(1'b1, 16'sd0, 15'd5, 16'sd7, 15'd9);
		send_word(1'b0, 16'sd0, 15'd1, 16'sd0, 15'd1);
		send_word(1'b0, 16'sd3, 15'd0, 16'sd4, 15'd5);
		send_word(1'b1, 16'sd3, 15'd5, 16'sd4, 15'd0);
		send_word(1'b1, 16'sd0, 15'd0, 16'sd0, 15'd0);
		send_word(1'b0, 16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7fff);
		send_word(1'b0, 16'sh7fff, 15'd1, 16'sh7fff, 15'd1);
		send_word(1'b0, -16'sd32767, 15'd1, -16'sd32767, 15'd1);
		send_word(1'b1, 16'sh7fff, 15'd1, 16'sh7fff, 15'd1);
		send_word(1'b1, -16'sd32767, 15'd1, 16'sh7fff, 15'd1);
		send_word(1'b1, 16'sh8000, 15'd1, 16'sh8000, 15'd1);
		send_word(1'b0, 16'sh8000, 15'd1, 16'sh8000, 15'd1);
		send_word(1'b0, 16'sh8000, 15'h7fff, 16'sh7fff, 15'd1);
		send_word(1'b1, 16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7fff);
		send_word(1'b1, -16'sd6, 15'd4, 16'sd10, 15'd15);
		send_word(1'b0, -16'sd5, 15'd6, 16'sd5, 15'd6);
		send_word(1'b0, 16'sd1, 15'h4000, 16'sd1, 15'h4000);
		send_word(1'b1, -16'sd1, 15'h5555, -16'sd1, 15'h2aaa);

		// Random fractions.
		for (n = 0; n < 900; n++) begin
			send_word(1'($urandom), pick_numer(), pick_denom(), pick_numer(), pick_denom());
		end
		req.valid <= 1'b0;

		// Drain, then let the pipeline settle for its full depth.
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#12000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
